// ===== rtl/gbc_pkg.sv =====
// Shared types and constants for the gyro bias calibrator.
// Holds the beat structs, the phase, operation and register codes, and the
// reciprocal constant for the final averaging divide. No dependencies.
package gbc_pkg;

	// Number of samples averaged once the sensor is judged still.
	localparam int AVG_SAMPLES = 2000;

	// Field and register widths.
	localparam int RATE_W   = 16;
	localparam int PHASE_W  = 2;
	localparam int LIMIT_W  = 26;
	localparam int WIN_W    = 10;
	localparam int CNT_W    = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 26;

	// The stillness sum holds at most 1023 differences of up to 65535.
	localparam int STILL_W = LIMIT_W;

	// Averaging sum: at most AVG_SAMPLES samples of 16 bits each.
	localparam int AVG_LOG  = $clog2(AVG_SAMPLES);
	localparam int MAG_W    = RATE_W + AVG_LOG;
	localparam int SUM_W    = MAG_W;

	// Divide by AVG_SAMPLES as a multiply by a rounded-up reciprocal. With
	// the shift set to the magnitude width plus the divisor's log, the
	// product's top bits are the exact floor for every magnitude in range.
	localparam int DIV_SHIFT = MAG_W + AVG_LOG;
	localparam int RECIP_W   = MAG_W + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << DIV_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int QUO_W  = PROD_W - DIV_SHIFT;

	// Calibration phases.
	localparam logic [PHASE_W-1:0] PH_STILL = 2'd0;
	localparam logic [PHASE_W-1:0] PH_AVG   = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DONE  = 2'd2;

	// What the tail of the pipeline does to the offset registers.
	localparam logic [1:0] OP_HOLD  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STILL_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN     = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 26'd100;
	localparam logic [WIN_W-1:0]   WIN_RST   = 10'd400;

	typedef struct packed {
		logic                     restart;
		logic signed [RATE_W-1:0] rate_x;
		logic signed [RATE_W-1:0] rate_y;
		logic signed [RATE_W-1:0] rate_z;
	} in_beat_t;

	typedef struct packed {
		logic [PHASE_W-1:0]       phase;
		logic signed [RATE_W-1:0] offset_x;
		logic signed [RATE_W-1:0] offset_y;
		logic signed [RATE_W-1:0] offset_z;
	} out_beat_t;

endpackage

// ===== rtl/gyro_bias_calibrator_top.sv =====
// Top level of the gyro bias calibrator: stillness check, averaging and
// offset hold for three gyro axes, with an output beat buffer.
// Depends on gbc_pkg for beat types, codes and the divide constant.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | into      | in_valid / in_ready   | in_data: restart, rate_x/y/z
//  out     | out of    | out_valid / out_ready | out_data: phase, offset_x/y/z
//  cfg     | into      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The block takes one input beat per cycle while in_ready is high and returns
// exactly one result beat for each. Each beat passes through the input
// register, the state update stage, the reciprocal multiply stage and the
// offset update stage that writes the result buffer.
// Reset clears every state and buffer pointer and loads the configuration
// registers with a limit of 100 and a window of 400 samples. A stalled output
// fills an eight-beat result buffer; in_ready drops only when eight beats are
// in flight, so in_ready never depends on out_ready in the same cycle.
// The configuration port is always ready.
module gyro_bias_calibrator_top import gbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_beat_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int OCC_W = PTR_W + 1;

	// Configuration registers.
	logic [LIMIT_W-1:0] limit_q;
	logic [WIN_W-1:0]   win_len_q;

	// Occupancy counts every beat between acceptance and delivery.
	logic [OCC_W-1:0] occ_q;
	logic             in_acc;
	logic             out_acc;

	// Stage 1: registered input beat.
	logic     v_s1;
	in_beat_t beat_s1;

	// Calibration state.
	logic [PHASE_W-1:0]        phase_q;
	logic signed [RATE_W-1:0]  prev_q [3];
	logic [STILL_W-1:0]        still_q [3];
	logic signed [SUM_W-1:0]   avg_q [3];
	logic [CNT_W-1:0]          cnt_q;

	// Next-state logic of stage 1.
	logic signed [RATE_W-1:0]  samp [3];
	logic signed [RATE_W:0]    diff [3];
	logic [RATE_W-1:0]         absd [3];
	logic [STILL_W-1:0]        still_add [3];
	logic signed [SUM_W-1:0]   avg_add [3];
	logic [MAG_W-1:0]          avg_mag [3];
	logic [CNT_W-1:0]          cnt_inc;
	logic                      moving;
	logic [PHASE_W-1:0]        nx_phase;
	logic signed [RATE_W-1:0]  nx_prev [3];
	logic [STILL_W-1:0]        nx_still [3];
	logic signed [SUM_W-1:0]   nx_avg [3];
	logic [CNT_W-1:0]          nx_cnt;
	logic [1:0]                nx_op;

	// Stage 2: operation and sum magnitude for the divide.
	logic               v_s2;
	logic [PHASE_W-1:0] phase_s2;
	logic [1:0]         op_s2;
	logic [MAG_W-1:0]   mag_s2 [3];
	logic               neg_s2 [3];
	logic [PROD_W-1:0]  prod [3];

	// Stage 3: quotient and offset update.
	logic               v_s3;
	logic [PHASE_W-1:0] phase_s3;
	logic [1:0]         op_s3;
	logic [QUO_W-1:0]   quo_s3 [3];
	logic               neg_s3 [3];
	logic [QUO_W-1:0]   quo_neg [3];
	logic signed [RATE_W-1:0] off_q [3];
	logic signed [RATE_W-1:0] nx_off [3];
	out_beat_t          res_beat;

	// Result buffer.
	out_beat_t        fifo_mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0] fifo_cnt_q;

	assign in_ready  = (occ_q != OCC_W'(FIFO_DEPTH));
	assign in_acc    = in_valid & in_ready;
	assign out_valid = (fifo_cnt_q != '0);
	assign out_acc   = out_valid & out_ready;
	assign out_data  = fifo_mem[rd_ptr_q];
	assign cfg_ready = 1'b1;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RST;
			win_len_q <= WIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STILL_LIMIT: limit_q   <= cfg_data[LIMIT_W-1:0];
				REG_WIN_LEN:     win_len_q <= cfg_data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_acc) - OCC_W'(out_acc);
		end
	end

	// Stage 1 input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			beat_s1 <= in_data;
		end
	end

	assign samp[0] = beat_s1.rate_x;
	assign samp[1] = beat_s1.rate_y;
	assign samp[2] = beat_s1.rate_z;

	// Per-axis arithmetic for both the stillness and the averaging phase.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {samp[i][RATE_W-1], samp[i]} - {prev_q[i][RATE_W-1], prev_q[i]};
			absd[i] = diff[i][RATE_W] ? RATE_W'(-diff[i]) : diff[i][RATE_W-1:0];
			still_add[i] = still_q[i] + STILL_W'(absd[i]);
			avg_add[i] = avg_q[i] + SUM_W'(samp[i]);
			avg_mag[i] = avg_add[i][SUM_W-1] ? MAG_W'(-avg_add[i]) : MAG_W'(avg_add[i]);
		end
	end

	// Phase sequencing. A window ends when the incremented count reaches the
	// window length, so a length of zero behaves as a length of one.
	always_comb begin
		nx_phase = phase_q;
		nx_prev  = prev_q;
		nx_still = still_q;
		nx_avg   = avg_q;
		nx_cnt   = cnt_q;
		nx_op    = OP_HOLD;
		cnt_inc  = cnt_q + CNT_W'(1);
		moving   = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (still_add[i] >= limit_q) begin
				moving = 1'b1;
			end
		end
		if (beat_s1.restart) begin
			nx_phase = PH_STILL;
			nx_cnt   = '0;
			nx_op    = OP_CLEAR;
			for (int i = 0; i < 3; i++) begin
				nx_prev[i]  = '0;
				nx_still[i] = '0;
				nx_avg[i]   = '0;
			end
		end else begin
			unique case (phase_q)
				PH_STILL: begin
					nx_prev  = samp;
					nx_still = still_add;
					nx_cnt   = cnt_inc;
					if (cnt_inc >= CNT_W'(win_len_q)) begin
						nx_cnt = '0;
						for (int i = 0; i < 3; i++) begin
							nx_still[i] = '0;
						end
						if (!moving) begin
							nx_phase = PH_AVG;
						end
					end
				end
				PH_AVG: begin
					nx_avg = avg_add;
					nx_cnt = cnt_inc;
					if (cnt_inc >= CNT_W'(AVG_SAMPLES)) begin
						nx_cnt   = '0;
						nx_phase = PH_DONE;
						nx_op    = OP_LOAD;
						for (int i = 0; i < 3; i++) begin
							nx_avg[i] = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STILL;
			cnt_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i]  <= '0;
				still_q[i] <= '0;
				avg_q[i]   <= '0;
			end
		end else if (v_s1) begin
			phase_q <= nx_phase;
			cnt_q   <= nx_cnt;
			prev_q  <= nx_prev;
			still_q <= nx_still;
			avg_q   <= nx_avg;
		end
	end

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			phase_s2 <= nx_phase;
			op_s2    <= nx_op;
			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= avg_mag[i];
				neg_s2[i] <= avg_add[i][SUM_W-1];
			end
		end
	end

	// Reciprocal multiply; the quotient is the top bits of the product.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = PROD_W'(mag_s2[i]) * PROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			phase_s3 <= phase_s2;
			op_s3    <= op_s2;
			for (int i = 0; i < 3; i++) begin
				quo_s3[i] <= prod[i][PROD_W-1:DIV_SHIFT];
				neg_s3[i] <= neg_s2[i];
			end
		end
	end

	// Offsets are updated in beat order at the tail, so every beat sees the
	// offsets left by the beats ahead of it. The quotient is a magnitude, so
	// negating it gives truncation toward zero.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo_neg[i] = -quo_s3[i];
			case (op_s3)
				OP_CLEAR: nx_off[i] = '0;
				OP_LOAD:  nx_off[i] = neg_s3[i] ? quo_neg[i][RATE_W-1:0]
				                                : quo_s3[i][RATE_W-1:0];
				default:  nx_off[i] = off_q[i];
			endcase
		end
		res_beat.phase    = phase_s3;
		res_beat.offset_x = nx_off[0];
		res_beat.offset_y = nx_off[1];
		res_beat.offset_z = nx_off[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				off_q[i] <= '0;
			end
		end else if (v_s3) begin
			off_q <= nx_off;
		end
	end

	// Result buffer; the occupancy limit keeps it from overflowing.
	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_mem[wr_ptr_q] <= res_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + OCC_W'(v_s3) - OCC_W'(out_acc);
		end
	end

	// Beats waiting in the buffer are a subset of the beats in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= occ_q)
		else $error("result buffer holds more beats than are in flight");

	// The tail never writes into a full buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (fifo_cnt_q != OCC_W'(FIFO_DEPTH)))
		else $error("result written into a full buffer");

	// A restart reaching the tail leaves all offsets at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && op_s3 == OP_CLEAR) |=>
		(off_q[0] == '0 && off_q[1] == '0 && off_q[2] == '0))
		else $error("offsets not cleared after restart");

	// Once the offsets are held, the sample counter is idle at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> (cnt_q == '0))
		else $error("sample counter running while offsets are held");

	// The averaging counter never passes the sample count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_AVG) |-> (cnt_q < CNT_W'(AVG_SAMPLES)))
		else $error("averaging counter out of range");

endmodule

// ===== tb/gbc_sb_pkg.sv =====
// Scoreboard for the gyro bias calibrator testbench: a cycle-free model of the
// stillness check, averaging and offset hold, plus the queue of result beats
// still owed by the block. Depends on gbc_pkg for beat types and codes.
package gbc_sb_pkg;
	import gbc_pkg::*;

	class calib_scoreboard;
		// Configuration copy, written whenever the testbench writes a register.
		logic [LIMIT_W-1:0]       still_limit;
		logic [WIN_W-1:0]         win_len;

		// Calibration state as the block should hold it.
		logic [PHASE_W-1:0]       phase;
		logic signed [RATE_W-1:0] prev_rate[3];
		longint                   axis_acc[3];
		logic [CNT_W-1:0]         sample_cnt;
		logic signed [RATE_W-1:0] offset[3];

		out_beat_t                pending_results[$];

		int errors;
		int n_results;
		int n_still_windows;
		int n_moving_windows;
		int n_calibrations;
		int n_restarts;
		int n_reg_writes;

		function new();
			still_limit = LIMIT_RST;
			win_len     = WIN_RST;
			clear_state();
		endfunction

		function void clear_state();
			phase      = PH_STILL;
			sample_cnt = '0;
			for (int i = 0; i < 3; i++) begin
				prev_rate[i] = '0;
				axis_acc[i]  = 0;
				offset[i]    = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			n_reg_writes++;
			case (idx)
				REG_STILL_LIMIT: still_limit = val[LIMIT_W-1:0];
				REG_WIN_LEN:     win_len     = val[WIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Advances the calibration by one accepted input beat and queues the
		// result beat that it must produce.
		function void note_sample(in_beat_t b);
			logic signed [RATE_W-1:0] s[3];
			longint                   d;
			bit                       moving;
			out_beat_t                want;

			s[0] = b.rate_x;
			s[1] = b.rate_y;
			s[2] = b.rate_z;
			if (b.restart) begin
				clear_state();
				n_restarts++;
			end else if (phase == PH_STILL) begin
				moving = 1'b0;
				for (int i = 0; i < 3; i++) begin
					d = longint'(s[i]) - longint'(prev_rate[i]);
					axis_acc[i] += (d < 0) ? -d : d;
					prev_rate[i] = s[i];
				end
				sample_cnt = sample_cnt + 1'b1;
				// A window length of zero behaves like one.
				if (sample_cnt >= win_len) begin
					for (int i = 0; i < 3; i++)
						if (axis_acc[i] >= longint'(still_limit))
							moving = 1'b1;
					for (int i = 0; i < 3; i++)
						axis_acc[i] = 0;
					sample_cnt = '0;
					if (moving) begin
						n_moving_windows++;
					end else begin
						n_still_windows++;
						phase = PH_AVG;
					end
				end
			end else if (phase == PH_AVG) begin
				for (int i = 0; i < 3; i++)
					axis_acc[i] += longint'(s[i]);
				sample_cnt = sample_cnt + 1'b1;
				if (sample_cnt >= AVG_SAMPLES) begin
					// Integer divide truncates toward zero, as the block must.
					for (int i = 0; i < 3; i++) begin
						offset[i]   = RATE_W'(axis_acc[i] / AVG_SAMPLES);
						axis_acc[i] = 0;
					end
					sample_cnt = '0;
					phase      = PH_DONE;
					n_calibrations++;
				end
			end
			want.phase    = phase;
			want.offset_x = offset[0];
			want.offset_y = offset[1];
			want.offset_z = offset[2];
			pending_results.push_back(want);
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t want;

			n_results++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: phase %0d offsets %0d %0d %0d",
					got.phase, got.offset_x, got.offset_y, got.offset_z);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.phase !== want.phase) begin
				$error("phase: expected %0d, got %0d", want.phase, got.phase);
				errors++;
			end
			if (got.offset_x !== want.offset_x) begin
				$error("offset_x: expected %0d, got %0d", want.offset_x, got.offset_x);
				errors++;
			end
			if (got.offset_y !== want.offset_y) begin
				$error("offset_y: expected %0d, got %0d", want.offset_y, got.offset_y);
				errors++;
			end
			if (got.offset_z !== want.offset_z) begin
				$error("offset_z: expected %0d, got %0d", want.offset_z, got.offset_z);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== tb/gyro_bias_calibrator_top_tb.sv =====
// Testbench top for the gyro bias calibrator: drives sample and register
// beats with random pacing and checks every result beat against the scoreboard.
// Depends on gbc_pkg, gbc_sb_pkg and the gyro_bias_calibrator_top RTL.
module gyro_bias_calibrator_top_tb;
	import gbc_pkg::*;
	import gbc_sb_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int N_RANDOM     = 1150;
	// Extra cycles after the last result before touching the registers or
	// ending the run; the block's pipeline is four stages deep.
	localparam int DRAIN_CYCLES = 10;
	// Length of each deliberate output stall, long enough to fill the buffer.
	localparam int HOLD_CYCLES  = 300;
	// Generous bound on the whole run, in clock cycles.
	localparam int MAX_CYCLES   = 200000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_beat_t  in_data   = '0;
	logic      out_ready = 1'b0;
	logic      cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_STILL_LIMIT;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic      in_ready;
	logic      out_valid;
	logic      cfg_ready;
	out_beat_t out_data;

	calib_scoreboard sb = new();

	// Sender pacing state: beats left in the current burst, beats accepted.
	int burst_left = 0;
	int n_sent     = 0;

	gyro_bias_calibrator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the block stops answering.
	initial begin
		#(CLK_PERIOD * MAX_CYCLES);
		$display("tb: failure");
		$finish;
	end

	// Every result beat is checked at the rising edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// The receiver follows its own stall pattern: runs of always ready, coin
	// flips, rare stalls and short dead stretches. Twice in the run it holds
	// off for a long stretch while the sender keeps offering beats, so that
	// the result buffer fills up and in_ready has to drop.
	initial begin
		int hold_left;
		int mode;
		int mode_left;
		int next_hold_at;

		hold_left    = 0;
		mode         = 0;
		mode_left    = 0;
		next_hold_at = 200;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && next_hold_at > 0 && sb.n_results >= next_hold_at) begin
				hold_left    = HOLD_CYCLES;
				next_hold_at = (next_hold_at < 700) ? 700 : 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(5, 60);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= 1'b0;
				endcase
			end
		end
	end

	function automatic in_beat_t mk_beat(logic rst, int x, int y, int z);
		in_beat_t b;

		b.restart = rst;
		b.rate_x  = RATE_W'(x);
		b.rate_y  = RATE_W'(y);
		b.rate_z  = RATE_W'(z);
		return b;
	endfunction

	// Any bit pattern at all, with the given restart flag.
	function automatic in_beat_t random_beat(logic rst);
		return mk_beat(rst, int'($urandom), int'($urandom), int'($urandom));
	endfunction

	// A sample close to a resting value, clamped to the 16-bit range.
	function automatic int near_rate(int base, int spread);
		int v;

		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v;
	endfunction

	// Offers one sample beat and returns at the falling edge after it was
	// taken. Valid is left high; the next beat or a gap decides its value,
	// so it never gets two updates in one time step.
	task automatic send_beat(input in_beat_t b);
		int gap;

		if (burst_left == 0) begin
			// Mostly short bursts, now and then a long one with no idling.
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(b);
		n_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// The sender stops and waits until every owed result has come back, then
	// lets the pipeline settle. Register writes only ever follow this.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned limit, input int unsigned win);
		write_reg(REG_STILL_LIMIT, CFG_DATA_W'(limit));
		write_reg(REG_WIN_LEN, CFG_DATA_W'(win));
		cfg_valid <= 1'b0;
	endtask

	// Random traffic. Most sequences look like a sensor at rest with a little
	// noise and the odd spike, so that windows pass and averaging starts; the
	// rest is raw noise and bursts of restarts. Between sequences the
	// registers are sometimes changed, always after the block has drained.
	task automatic random_stretch(input int count);
		int start;
		int kind;
		int spread;
		int n;
		int base[3];
		int unsigned limit;
		int unsigned win;

		start = n_sent;
		while (n_sent - start < count) begin
			if ($urandom_range(0, 5) == 0) begin
				wait_for_results();
				case ($urandom_range(0, 9))
					0: win = 0;
					1: win = (1 << WIN_W) - 1;
					default: win = $urandom_range(1, 12);
				endcase
				case ($urandom_range(0, 9))
					0: limit = 0;
					1: limit = (1 << LIMIT_W) - 1;
					default: limit = $urandom_range(1, 300);
				endcase
				configure(limit, win);
			end
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				for (int i = 0; i < 3; i++)
					base[i] = int'($urandom_range(0, 4000)) - 2000;
				spread = $urandom_range(0, 8);
				if ($urandom_range(0, 2) != 0)
					send_beat(random_beat(1'b1));
				n = $urandom_range(1, 40);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 19) == 0)
						send_beat(random_beat(1'b0));
					else
						send_beat(mk_beat(1'b0, near_rate(base[0], spread),
							near_rate(base[1], spread), near_rate(base[2], spread)));
				end
			end else if (kind < 9) begin
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					send_beat(random_beat($urandom_range(0, 9) == 0));
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send_beat(random_beat(1'b1));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: a 400-sample window never closes here, so the phase
		// must stay at the stillness check through extremes and a restart.
		send_beat(mk_beat(1'b0, 32767, -32768, 0));
		send_beat(mk_beat(1'b0, -32768, 32767, -1));
		send_beat(mk_beat(1'b0, 0, 0, 0));
		send_beat(mk_beat(1'b1, -1, -1, -1));
		send_beat(mk_beat(1'b0, 1, -1, 0));

		// A zero limit: every window counts as moving, even a flat one.
		wait_for_results();
		configure(0, 1);
		send_beat(mk_beat(1'b0, 0, 0, 0));
		send_beat(mk_beat(1'b0, 5, 5, 5));

		// A zero window length acts as one sample, and the first window after
		// a restart includes the jump from zero; the largest limit lets it pass.
		wait_for_results();
		configure((1 << LIMIT_W) - 1, 0);
		send_beat(mk_beat(1'b1, 0, 0, 0));
		send_beat(mk_beat(1'b0, 32767, -32768, 32767));
		send_beat(mk_beat(1'b0, -32768, -32768, -32768));
		send_beat(mk_beat(1'b0, 32767, 32767, 32767));

		// Limit three over two-sample windows: a sum of one passes, a sum of
		// exactly three is moving, and the next window keeps the last sample.
		wait_for_results();
		configure(3, 2);
		send_beat(mk_beat(1'b1, 0, 0, 0));
		send_beat(mk_beat(1'b0, 1, 0, 0));
		send_beat(mk_beat(1'b0, 1, 0, 0));
		send_beat(mk_beat(1'b1, 0, 0, 0));
		send_beat(mk_beat(1'b0, 2, 0, 0));
		send_beat(mk_beat(1'b0, 3, 0, 0));
		send_beat(mk_beat(1'b0, 3, 0, 0));
		send_beat(mk_beat(1'b0, 3, 0, 0));
		send_beat(mk_beat(1'b1, 0, 0, 0));

		random_stretch(N_RANDOM);

		wait_for_results();
		$display("tb: %0d sample beats sent, %0d result beats checked, %0d register writes",
			n_sent, sb.n_results, sb.n_reg_writes);
		$display("tb: %0d still and %0d moving windows, %0d calibrations finished, %0d restarts",
			sb.n_still_windows, sb.n_moving_windows, sb.n_calibrations, sb.n_restarts);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== gyro_bias_calibrator_top.f =====
rtl/gbc_pkg.sv
rtl/gyro_bias_calibrator_top.sv
tb/gbc_sb_pkg.sv
tb/gyro_bias_calibrator_top_tb.sv
